@@ rtl/clps_pkg.sv @@
// Shared constants, types and codes for the compacting list with priority sort.
`timescale 1ns / 1ps

package clps_pkg;

  localparam int DEPTH     = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int POS_W     = 6;
  localparam int KIND_W    = 2;
  localparam int KEY_W     = 16;
  localparam int HANDLE_W  = 16;
  localparam int OUT_CNT_W = 6;
  localparam int CMP_W     = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GET    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SORT   = 2'd3;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [POS_W-1:0]    position;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } item_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic                 valid;
    status_t              status;
    logic [OUT_CNT_W-1:0] count;
    entry_t               entry;
  } result_t;

endpackage

@@ rtl/clps_mem.sv @@
// Entry memory with one write port and one registered read port.
`timescale 1ns / 1ps

module clps_mem
  import clps_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rd_data
);

  entry_t mem_r [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem_r[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/clps_ctrl.sv @@
// Request sequencer for append, delete, get and sort, with the key compare used by sort.
`timescale 1ns / 1ps

module clps_ctrl
  import clps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  item_t    item,
  input  logic     item_valid,
  output logic     idle,
  input  logic     out_free,
  output result_t  res,
  output mem_req_t mem_req,
  input  entry_t   rd_data
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_GET      = 9'b000000010,
    S_DEL_RD   = 9'b000000100,
    S_DEL_WR   = 9'b000001000,
    S_SORT_LD  = 9'b000010000,
    S_SORT_KEY = 9'b000100000,
    S_SORT_CMP = 9'b001000000,
    S_SORT_PUT = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  entry_t           x_r, x_nxt;
  status_t          status_r, status_nxt;
  entry_t           entry_r, entry_nxt;

  logic             accept;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] pos_m1;
  logic [IDX_W-1:0] pos_idx;
  logic             pos_ok;
  logic             last_i;

  assign accept  = (state_r == S_IDLE) && item_valid;
  assign pos_ext = CMP_W'(item.position);
  assign pos_m1  = pos_ext - CMP_W'(1);
  assign pos_idx = pos_m1[IDX_W-1:0];
  assign pos_ok  = (pos_ext != '0) && (pos_ext <= CMP_W'(count_r));
  assign last_i  = (CNT_W'(i_r) + CNT_W'(1)) >= count_r;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    i_nxt      = i_r;
    x_nxt      = x_r;
    status_nxt = status_r;
    entry_nxt  = entry_r;
    mem_req    = '0;
    res        = '0;
    case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          status_nxt = ST_OK;
          entry_nxt  = '0;
          state_nxt  = S_DONE;
          case (item.kind)
            KIND_APPEND: begin
              if (count_r >= CNT_W'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                mem_req.we           = 1'b1;
                mem_req.waddr        = count_r[IDX_W-1:0];
                mem_req.wdata.key    = item.key;
                mem_req.wdata.handle = item.handle;
                count_nxt            = count_r + CNT_W'(1);
              end
            end
            KIND_DELETE: begin
              if (!pos_ok) begin
                status_nxt = ST_RANGE;
              end else begin
                ptr_nxt = pos_idx;
                if ((CNT_W'(pos_idx) + CNT_W'(1)) >= count_r) begin
                  count_nxt = count_r - CNT_W'(1);
                end else begin
                  state_nxt = S_DEL_RD;
                end
              end
            end
            KIND_GET: begin
              if (!pos_ok) begin
                status_nxt = ST_RANGE;
              end else begin
                mem_req.raddr = pos_idx;
                state_nxt     = S_GET;
              end
            end
            KIND_SORT: begin
              if (count_r >= CNT_W'(2)) begin
                i_nxt     = IDX_W'(1);
                state_nxt = S_SORT_LD;
              end
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_GET: begin
        entry_nxt = rd_data;
        state_nxt = S_DONE;
      end
      S_DEL_RD: begin
        mem_req.raddr = ptr_r + IDX_W'(1);
        state_nxt     = S_DEL_WR;
      end
      S_DEL_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_r;
        mem_req.wdata = rd_data;
        ptr_nxt       = ptr_r + IDX_W'(1);
        if ((CNT_W'(ptr_r) + CNT_W'(2)) >= count_r) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DEL_RD;
        end
      end
      S_SORT_LD: begin
        mem_req.raddr = i_r;
        state_nxt     = S_SORT_KEY;
      end
      S_SORT_KEY: begin
        x_nxt         = rd_data;
        ptr_nxt       = i_r;
        mem_req.raddr = i_r - IDX_W'(1);
        state_nxt     = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_r;
        if (x_r.key < rd_data.key) begin
          mem_req.wdata = rd_data;
          ptr_nxt       = ptr_r - IDX_W'(1);
          if (ptr_r == IDX_W'(1)) begin
            state_nxt = S_SORT_PUT;
          end else begin
            mem_req.raddr = ptr_r - IDX_W'(2);
          end
        end else begin
          mem_req.wdata = x_r;
          if (last_i) begin
            state_nxt = S_DONE;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = S_SORT_LD;
          end
        end
      end
      S_SORT_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_r;
        mem_req.wdata = x_r;
        if (last_i) begin
          state_nxt = S_DONE;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = S_SORT_LD;
        end
      end
      S_DONE: begin
        res.valid  = out_free;
        res.status = status_r;
        res.count  = OUT_CNT_W'(count_r);
        res.entry  = entry_r;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign idle = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    i_r      <= i_nxt;
    x_r      <= x_nxt;
    status_r <= status_nxt;
    entry_r  <= entry_nxt;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("Entry count exceeds the list depth.");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (item.kind == KIND_APPEND) && (count_r < CNT_W'(DEPTH))
    |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("Accepted append did not grow the list by one.");

  a_sort_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SORT_LD || state_r == S_SORT_KEY || state_r == S_SORT_CMP ||
     state_r == S_SORT_PUT) |=> $stable(count_r))
    else $error("Sort changed the entry count.");

  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r != S_IDLE || (accept && item.kind == KIND_APPEND)))
    else $error("Memory written while idle without an append.");

  a_sort_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SORT_CMP) |-> (ptr_r != '0) && (ptr_r <= i_r) &&
    (CNT_W'(i_r) < count_r))
    else $error("Sort insertion point left the sorted prefix.");
`endif

endmodule

@@ rtl/compacting_list_with_priority_sort.sv @@
// Top level of the compacting list with priority sort and its result register.
`timescale 1ns / 1ps

// The list holds up to DEPTH entries of a 16-bit priority and a 16-bit handle in a
// single memory with one write port and one registered read port, and a small
// sequencer works each request through that port with one key comparator. One
// request is taken at a time and gives one result beat. Append writes the new
// entry at the end of the list, get reads the entry at the position, delete reads
// each later entry and writes it back one slot lower, and sort takes each entry
// after the first and moves it past every earlier entry with a larger key, each
// of which moves one slot up. A finished result waits in the output register
// while the next request is accepted. A result that cannot enter the register
// because the previous beat is still held keeps the sequencer busy and the input
// stalled.

module compacting_list_with_priority_sort
  import clps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [POS_W-1:0]     in_position,
  input  logic [KEY_W-1:0]     in_entry_priority,
  input  logic [HANDLE_W-1:0]  in_entry_payload,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic [OUT_CNT_W-1:0] out_entry_count,
  output logic [KEY_W-1:0]     out_read_priority,
  output logic [HANDLE_W-1:0]  out_read_payload
);

  item_t    item;
  logic     idle;
  logic     out_free;
  result_t  res;
  mem_req_t mem_req;
  entry_t   rd_data;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic [OUT_CNT_W-1:0] out_count_r;
  entry_t               out_entry_r;

  assign item.kind     = in_kind;
  assign item.position = in_position;
  assign item.key      = in_entry_priority;
  assign item.handle   = in_entry_payload;

  assign in_stall = !idle;
  assign out_free = !out_valid_r || !out_stall;

  clps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (in_valid),
    .idle       (idle),
    .out_free   (out_free),
    .res        (res),
    .mem_req    (mem_req),
    .rd_data    (rd_data)
  );

  clps_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_status_r <= res.status;
      out_count_r  <= res.count;
      out_entry_r  <= res.entry;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_entry_count   = out_count_r;
  assign out_read_priority = out_entry_r.key;
  assign out_read_payload  = out_entry_r.handle;

endmodule

@@ sim/compacting_list_with_priority_sort_tb.sv @@
// Self-checking testbench for the compacting list with priority sort.
`timescale 1ns / 1ps

module compacting_list_with_priority_sort_tb;
  import clps_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    status_t              status;
    logic [OUT_CNT_W-1:0] count;
    logic [KEY_W-1:0]     key;
    logic [HANDLE_W-1:0]  handle;
  } reply_t;

  typedef enum int {MIX_RUN, FILL_RUN, DRAIN_RUN} run_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [KIND_W-1:0]    in_kind = KIND_SORT;
  logic [POS_W-1:0]     in_position = '0;
  logic [KEY_W-1:0]     in_entry_priority = '0;
  logic [HANDLE_W-1:0]  in_entry_payload = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_status;
  logic [OUT_CNT_W-1:0] out_entry_count;
  logic [KEY_W-1:0]     out_read_priority;
  logic [HANDLE_W-1:0]  out_read_payload;

  item_t  request_q[$];
  reply_t reply_q[$];

  logic [KEY_W-1:0]    shadow_key[DEPTH];
  logic [HANDLE_W-1:0] shadow_handle[DEPTH];
  int                  shadow_len = 0;
  int                  plan_len = 0;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  hold_req = 0;
  int  hold_ack = 0;
  int  hold_left = 0;
  logic in_taken = 1'b0;

  int requests_queued = 0;
  int requests_taken = 0;
  int replies_seen = 0;
  int fail_cnt = 0;
  int quiet_cycles = 0;
  int full_cnt = 0;
  int range_cnt = 0;
  int sort_cnt = 0;
  int peak_len = 0;

  compacting_list_with_priority_sort u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_position       (in_position),
    .in_entry_priority (in_entry_priority),
    .in_entry_payload  (in_entry_payload),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_entry_count   (out_entry_count),
    .out_read_priority (out_read_priority),
    .out_read_payload  (out_read_payload)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic reply_t apply_request(input item_t req);
    reply_t              rsp;
    int                  j;
    logic [KEY_W-1:0]    k;
    logic [HANDLE_W-1:0] h;
    rsp = '{status: ST_OK, count: '0, key: '0, handle: '0};
    case (req.kind)
      KIND_APPEND: begin
        if (shadow_len >= DEPTH) begin
          rsp.status = ST_FULL;
          full_cnt++;
        end else begin
          shadow_key[shadow_len] = req.key;
          shadow_handle[shadow_len] = req.handle;
          shadow_len++;
        end
      end
      KIND_DELETE: begin
        if (req.position >= 1 && req.position <= shadow_len) begin
          for (j = req.position - 1; j + 1 < shadow_len; j++) begin
            shadow_key[j] = shadow_key[j + 1];
            shadow_handle[j] = shadow_handle[j + 1];
          end
          shadow_len--;
        end else begin
          rsp.status = ST_RANGE;
          range_cnt++;
        end
      end
      KIND_GET: begin
        if (req.position >= 1 && req.position <= shadow_len) begin
          rsp.key = shadow_key[req.position - 1];
          rsp.handle = shadow_handle[req.position - 1];
        end else begin
          rsp.status = ST_RANGE;
          range_cnt++;
        end
      end
      default: begin
        sort_cnt++;
        for (int i = 1; i < shadow_len; i++) begin
          j = i;
          while (j > 0 && shadow_key[j] < shadow_key[j - 1]) begin
            k = shadow_key[j];
            h = shadow_handle[j];
            shadow_key[j] = shadow_key[j - 1];
            shadow_handle[j] = shadow_handle[j - 1];
            shadow_key[j - 1] = k;
            shadow_handle[j - 1] = h;
            j--;
          end
        end
      end
    endcase
    if (shadow_len > peak_len) peak_len = shadow_len;
    rsp.count = shadow_len[OUT_CNT_W-1:0];
    return rsp;
  endfunction

  task automatic queue_request(input logic [KIND_W-1:0] kind, input int pos,
                               input int key, input int handle);
    item_t req;
    req.kind = kind;
    req.position = pos[POS_W-1:0];
    req.key = key[KEY_W-1:0];
    req.handle = handle[HANDLE_W-1:0];
    request_q.push_back(req);
    requests_queued++;
    if (kind == KIND_APPEND && plan_len < DEPTH) plan_len++;
    if (kind == KIND_DELETE && pos >= 1 && pos <= plan_len) plan_len--;
  endtask

  task automatic queue_random(input run_t run);
    int                r;
    int                pos;
    int                key;
    logic [KIND_W-1:0] kind;
    r = $urandom_range(0, 99);
    case (run)
      FILL_RUN:  kind = (r < 85) ? KIND_APPEND : (r < 95) ? KIND_GET : KIND_SORT;
      DRAIN_RUN: kind = (r < 65) ? KIND_DELETE : (r < 90) ? KIND_GET : KIND_SORT;
      default:   kind = (r < 40) ? KIND_APPEND : (r < 62) ? KIND_DELETE :
                        (r < 92) ? KIND_GET : KIND_SORT;
    endcase
    r = $urandom_range(0, 99);
    if (plan_len > 0 && r < 80) pos = $urandom_range(1, plan_len);
    else if (r < 88) pos = plan_len + 1;
    else if (r < 94) pos = 0;
    else pos = $urandom_range(0, 63);
    key = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 65535);
    queue_request(kind, pos, key, $urandom_range(0, 65535));
  endtask

  task automatic run_random(input int n);
    run_t run;
    int   seg;
    while (n > 0) begin
      run = run_t'($urandom_range(0, 2));
      seg = $urandom_range(10, 40);
      for (int i = 0; i < seg && n > 0; i++) begin
        queue_random(run);
        n--;
      end
    end
  endtask

  task automatic wait_drained;
    while (requests_taken != requests_queued || reply_q.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    item_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (request_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req = request_q.pop_front();
        in_valid <= 1'b1;
        in_kind <= req.kind;
        in_position <= req.position;
        in_entry_priority <= req.key;
        in_entry_payload <= req.handle;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    item_t  req;
    reply_t want;
    logic   in_fire;
    logic   out_fire;
    in_fire = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid && !out_stall;
    in_taken <= in_fire;
    if (in_fire) begin
      req.kind = in_kind;
      req.position = in_position;
      req.key = in_entry_priority;
      req.handle = in_entry_payload;
      reply_q.push_back(apply_request(req));
      requests_taken++;
    end
    if (out_fire) begin
      replies_seen++;
      if (reply_q.size() == 0) begin
        $error("result beat with no request outstanding");
        fail_cnt++;
      end else begin
        want = reply_q.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_cnt++;
        end
        if (out_entry_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, out_entry_count);
          fail_cnt++;
        end
        if (out_read_priority !== want.key) begin
          $error("read_priority: expected %0d, got %0d", want.key, out_read_priority);
          fail_cnt++;
        end
        if (out_read_payload !== want.handle) begin
          $error("read_payload: expected %0d, got %0d", want.handle, out_read_payload);
          fail_cnt++;
        end
      end
    end
    if (!rst_n || in_fire || out_fire) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("compacting_list_with_priority_sort_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 9;
    recv_idle_pct = 62;
    queue_request(KIND_SORT, 0, 0, 0);
    queue_request(KIND_GET, 0, 0, 0);
    queue_request(KIND_GET, 1, 0, 0);
    queue_request(KIND_DELETE, 1, 0, 0);
    queue_request(KIND_APPEND, 63, 16'hFFFF, 16'h0000);
    queue_request(KIND_SORT, 0, 0, 0);
    queue_request(KIND_GET, 1, 0, 0);
    queue_request(KIND_APPEND, 0, 16'h0000, 16'hFFFF);
    queue_request(KIND_APPEND, 0, 16'hFFFF, 16'h1234);
    queue_request(KIND_APPEND, 0, 16'h8000, 16'hAAAA);
    queue_request(KIND_APPEND, 0, 16'h0000, 16'h5555);
    queue_request(KIND_SORT, 0, 0, 0);
    queue_request(KIND_GET, 1, 0, 0);
    queue_request(KIND_GET, 2, 0, 0);
    queue_request(KIND_GET, 5, 0, 0);
    queue_request(KIND_GET, 6, 0, 0);
    queue_request(KIND_GET, 63, 0, 0);
    queue_request(KIND_DELETE, 5, 0, 0);
    queue_request(KIND_DELETE, 1, 0, 0);
    queue_request(KIND_DELETE, 0, 0, 0);
    queue_request(KIND_DELETE, 32, 0, 0);
    queue_request(KIND_GET, 3, 0, 0);
    run_random(530);
    wait_drained();

    send_idle_pct = 62;
    recv_idle_pct = 9;
    run_random(530);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 40; i++) queue_random(FILL_RUN);
    wait_drained();
    hold_req = hold_req + 1;
    for (int i = 0; i < 30; i++) queue_random(MIX_RUN);
    wait_drained();
    repeat (40) @(negedge clk);
    run_random(470);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d requests with %0d results; %0d sorts, %0d refused appends,",
             requests_taken, replies_seen, sort_cnt, full_cnt);
    $display("%0d out-of-range positions, list filled up to %0d entries.",
             range_cnt, peak_len);
    if (fail_cnt == 0 && reply_q.size() == 0) begin
      $display("compacting_list_with_priority_sort_tb OK");
    end else begin
      $display("compacting_list_with_priority_sort_tb NOT OK");
    end
    $finish;
  end

endmodule
